[hw/rtl/rcmo_pkg.sv]
// Relay controller with manual override: shared types, codes and constants.
// No dependencies.
package rcmo_pkg;

  // Device state codes
  localparam logic [1:0] ST_OFF     = 2'd0;
  localparam logic [1:0] ST_ON      = 2'd1;
  localparam logic [1:0] ST_MAN_ON  = 2'd2;
  localparam logic [1:0] ST_MAN_OFF = 2'd3;

  // Button event codes
  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_SHORT = 2'd1;
  localparam logic [1:0] BTN_LONG  = 2'd2;

  // Control mode codes
  localparam logic [2:0] MODE_UNCFG = 3'd0;
  localparam logic [2:0] MODE_RAISE = 3'd1;
  localparam logic [2:0] MODE_LOWER = 3'd2;
  localparam logic [2:0] MODE_TIMED = 3'd3;
  localparam logic [2:0] MODE_AUX   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_CONTROL_MODE = 3'd0;
  localparam logic [2:0] REG_TARGET_LEVEL = 3'd1;
  localparam logic [2:0] REG_PHASE_COUNT  = 3'd2;
  localparam logic [2:0] REG_PHASE_SEC0   = 3'd3;

  localparam int unsigned MaxPhasesDef = 4;
  localparam int unsigned MsPerSecond  = 1000;
  localparam int unsigned MinPhases    = 2;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 32;
  localparam int unsigned PhaseIdxW    = 2;
  localparam int unsigned InDataW      = 72;
  localparam int unsigned OutDataW     = 8;

  typedef struct packed {
    logic [1:0]           cur_state;
    logic [1:0]           last_ctl_state;
    logic                 manual;
    logic [PhaseIdxW-1:0] phase_idx;
    logic [31:0]          phase_start_ms;
    logic [31:0]          last_update_ms;
    logic                 drive;
  } ctl_state_t;

  typedef struct packed {
    logic [1:0]         button_event;
    logic signed [31:0] sensor_value;
    logic               sensor_valid;
    logic [31:0]        now_ms;
    logic               paused;
    logic               aux_demand;
  } item_t;

endpackage

[hw/rtl/rcmo_core.sv]
// Relay controller next-state logic: button handling, mode decision, timed cycle.
// Depends on rcmo_pkg.
module rcmo_core import rcmo_pkg::*; #(
  parameter int unsigned MaxPhases = MaxPhasesDef
) (
  input  ctl_state_t         state_i,
  input  item_t              item_i,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] target_i,
  input  logic [2:0]         phase_count_i,
  input  logic [15:0]        phase_sec_i [MaxPhases],
  output ctl_state_t         state_o,
  output logic               changed_o
);

  logic [1:0]  btn_tgt;
  logic        press;
  logic [1:0]  cur_b;
  logic        man_b;
  logic        drive_upd;
  logic [2:0]  eff_count;
  logic [15:0] secs;
  logic [31:0] limit;
  logic [31:0] elapsed;
  logic        frozen;
  logic        fire;
  logic [2:0]  idx_inc;

  // Button: toggle into manual, or back to the last controlled state
  always_comb begin
    press   = 1'b1;
    btn_tgt = ST_MAN_ON;
    case (item_i.button_event)
      BTN_SHORT: btn_tgt = ST_MAN_ON;
      BTN_LONG:  btn_tgt = ST_MAN_OFF;
      default:   press   = 1'b0;
    endcase
    cur_b = state_i.cur_state;
    man_b = state_i.manual;
    if (press) begin
      if (state_i.cur_state == btn_tgt) begin
        man_b = 1'b0;
        cur_b = state_i.last_ctl_state;
      end else begin
        man_b = 1'b1;
        cur_b = btn_tgt;
      end
    end
  end

  // Timed cycle terms; elapsed time while frozen equals last_update - start
  always_comb begin
    if (phase_count_i < 3'(MinPhases)) begin
      eff_count = 3'(MinPhases);
    end else if (phase_count_i > 3'(MaxPhases)) begin
      eff_count = 3'(MaxPhases);
    end else begin
      eff_count = phase_count_i;
    end
    secs = '0;
    for (int i = 0; i < MaxPhases; i++) begin
      if (state_i.phase_idx == PhaseIdxW'(i)) begin
        secs = phase_sec_i[i];
      end
    end
    limit   = 32'(secs) * 32'(MsPerSecond);
    frozen  = item_i.paused | man_b;
    elapsed = frozen ? (state_i.last_update_ms - state_i.phase_start_ms)
                     : (item_i.now_ms - state_i.phase_start_ms);
    fire    = (elapsed >= limit);
    idx_inc = 3'(state_i.phase_idx) + 3'd1;
  end

  always_comb begin
    state_o           = state_i;
    state_o.cur_state = cur_b;
    state_o.manual    = man_b;
    drive_upd         = 1'b1;
    unique case (mode_i)
      MODE_RAISE: begin
        if (!man_b && item_i.sensor_valid) begin
          state_o.cur_state      = (item_i.sensor_value < target_i) ? ST_ON : ST_OFF;
          state_o.last_ctl_state = state_o.cur_state;
        end
      end
      MODE_LOWER: begin
        if (!man_b && item_i.sensor_valid) begin
          state_o.cur_state      = (item_i.sensor_value > target_i) ? ST_ON : ST_OFF;
          state_o.last_ctl_state = state_o.cur_state;
        end
      end
      MODE_TIMED: begin
        if (frozen) begin
          state_o.phase_start_ms = state_i.phase_start_ms
                                 + (item_i.now_ms - state_i.last_update_ms);
        end
        if (fire) begin
          // even phases are on phases: their end turns the relay off
          state_o.cur_state      = state_i.phase_idx[0] ? ST_ON : ST_OFF;
          state_o.last_ctl_state = state_o.cur_state;
          state_o.phase_idx      = (idx_inc >= eff_count) ? '0 : idx_inc[PhaseIdxW-1:0];
          state_o.phase_start_ms = item_i.now_ms;
        end
        state_o.last_update_ms = item_i.now_ms;
      end
      MODE_AUX: begin
        if (!man_b) begin
          state_o.cur_state      = item_i.aux_demand ? ST_ON : ST_OFF;
          state_o.last_ctl_state = state_o.cur_state;
        end
      end
      default: drive_upd = 1'b0;
    endcase
    if (drive_upd) begin
      state_o.drive = (state_o.cur_state == ST_ON) || (state_o.cur_state == ST_MAN_ON);
    end
    changed_o = (state_o.cur_state != state_i.cur_state);
  end

endmodule

[hw/rtl/relay_controller_with_manual_override.sv]
// Relay controller with manual override, top level.
// Path of a beat: input register, then next-state logic into the result
// register. Throughput: one beat per cycle unless the receiver stalls; the
// control state feeds back through a single register. Reset (rst_ni low,
// async): relay off, manual clear, phase index 1, times 0, mode unconfigured,
// phase count 2, all phase durations 0. Depends on rcmo_pkg.
module relay_controller_with_manual_override import rcmo_pkg::*; #(
  parameter int unsigned MaxPhases = MaxPhasesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [1:0] button_event, [33:2] sensor_value, [34] sensor_valid,
  // [66:35] now_ms, [67] paused, [68] aux_demand, [71:69] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] drive_on, [2:1] device_state, [3] state_changed, [7:4] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [2:0]         mode_q;
  logic signed [31:0] target_q;
  logic [2:0]         phase_count_q;
  logic [15:0]        phase_sec_q [MaxPhases];

  // Input stage
  logic  in_vld_q;
  item_t item_q;

  // Control state and result register
  ctl_state_t state_q, state_d;
  logic       changed_d;
  logic       out_vld_q;
  logic [3:0] out_q;
  logic       advance;

  // The item in the input register moves on when the result slot is free or
  // being drained this cycle; the input register refills in the same cycle.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_UNCFG;
      target_q      <= '0;
      phase_count_q <= 3'(MinPhases);
      for (int i = 0; i < MaxPhases; i++) begin
        phase_sec_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_CONTROL_MODE) begin
        mode_q <= cfg_data_i[2:0];
      end
      if (cfg_idx_i == REG_TARGET_LEVEL) begin
        target_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_PHASE_COUNT) begin
        phase_count_q <= cfg_data_i[2:0];
      end
      for (int i = 0; i < MaxPhases; i++) begin
        if (cfg_idx_i == REG_PHASE_SEC0 + CfgIdxW'(i)) begin
          phase_sec_q[i] <= cfg_data_i[15:0];
        end
      end
    end
  end

  // Input register: payload unpacked from the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.button_event <= s_axis_tdata[1:0];
      item_q.sensor_value <= s_axis_tdata[33:2];
      item_q.sensor_valid <= s_axis_tdata[34];
      item_q.now_ms       <= s_axis_tdata[66:35];
      item_q.paused       <= s_axis_tdata[67];
      item_q.aux_demand   <= s_axis_tdata[68];
    end
  end

  rcmo_core #(
    .MaxPhases(MaxPhases)
  ) u_core (
    .state_i      (state_q),
    .item_i       (item_q),
    .mode_i       (mode_q),
    .target_i     (target_q),
    .phase_count_i(phase_count_q),
    .phase_sec_i  (phase_sec_q),
    .state_o      (state_d),
    .changed_o    (changed_d)
  );

  // Control state commits together with the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cur_state      <= ST_OFF;
      state_q.last_ctl_state <= ST_OFF;
      state_q.manual         <= 1'b0;
      state_q.phase_idx      <= PhaseIdxW'(1);
      state_q.phase_start_ms <= '0;
      state_q.last_update_ms <= '0;
      state_q.drive          <= 1'b0;
      out_vld_q              <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= {changed_d, state_d.cur_state, state_d.drive};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_q};

endmodule

[verif/testbench.sv]
// Testbench for relay_controller_with_manual_override: control updates go in as
// stream beats, and each result beat is checked against a local predictor.
// Depends on rcmo_pkg and the relay_controller_with_manual_override RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rcmo_pkg::*;

  localparam int ResetCycles  = 11;
  localparam int IdleLimit    = 2000;  // cycles with no beat on either side
  localparam int SettleCycles = 4;     // margin to let the pipe empty
  localparam int LongHold     = 80;    // receiver hold-off, cycles
  localparam int MaxPrinted   = 100;

  // Button code three has no name in the package; the block treats it as no press.
  localparam logic [1:0] BTN_UNUSED = 2'd3;
  // Highest mode code; not a defined mode, so only the buttons act.
  localparam logic [2:0] MODE_SPARE = 3'd7;

  localparam logic signed [31:0] LevelMin = 32'sh8000_0000;
  localparam logic signed [31:0] LevelMax = 32'sh7FFF_FFFF;

  // One result beat, field by field.
  typedef struct packed {
    logic       drive_on;
    logic [1:0] device_state;
    logic       state_changed;
  } relay_out_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [1:0] button_event, [33:2] sensor_value, [34] sensor_valid,
  // [66:35] now_ms, [67] paused, [68] aux_demand, [71:69] zero
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [0] drive_on, [2:1] device_state, [3] state_changed, [7:4] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predictor copy of the control state and the register file.
  ctl_state_t         relay_st;
  logic [2:0]         mode_reg;
  logic signed [31:0] target_reg;
  logic [2:0]         count_reg;
  logic [15:0]        secs_reg [MaxPhasesDef];

  relay_out_t  pending_results_q [$];
  int          mismatches   = 0;
  int          idle_cycles  = 0;
  int          sink_hold_len = 0;
  bit          src_gaps_on  = 1'b1;
  bit          sink_gaps_on = 1'b1;
  logic [31:0] clock_ms     = '0;  // running timestamp for random updates

  always #5 clk_i = ~clk_i;

  relay_controller_with_manual_override dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Automatic control decision: state and last controlled state move together.
  function automatic void take_control(logic [1:0] s);
    relay_st.cur_state      = s;
    relay_st.last_ctl_state = s;
  endfunction

  // Applies one update to the predicted state and returns the expected beat.
  function automatic relay_out_t predict_relay(item_t u);
    logic [1:0]  prior;
    logic [1:0]  press_state;
    logic [31:0] elapsed;
    logic [31:0] limit;
    int unsigned next_idx;
    int unsigned phases;
    logic        drive_follows;
    relay_out_t  r;
    prior         = relay_st.cur_state;
    drive_follows = 1'b1;

    // A press toggles its manual state; pressing it again restores control.
    if (u.button_event == BTN_SHORT || u.button_event == BTN_LONG) begin
      press_state = (u.button_event == BTN_SHORT) ? ST_MAN_ON : ST_MAN_OFF;
      if (relay_st.cur_state == press_state) begin
        relay_st.manual    = 1'b0;
        relay_st.cur_state = relay_st.last_ctl_state;
      end else begin
        relay_st.manual    = 1'b1;
        relay_st.cur_state = press_state;
      end
    end

    case (mode_reg)
      MODE_RAISE: begin
        if (!relay_st.manual && u.sensor_valid)
          take_control(u.sensor_value < target_reg ? ST_ON : ST_OFF);
      end
      MODE_LOWER: begin
        if (!relay_st.manual && u.sensor_valid)
          take_control(u.sensor_value > target_reg ? ST_ON : ST_OFF);
      end
      MODE_TIMED: begin
        // Paused or manual: shift the phase start so the elapsed time is frozen.
        if (u.paused || relay_st.manual)
          relay_st.phase_start_ms = relay_st.phase_start_ms +
                                    (u.now_ms - relay_st.last_update_ms);
        limit   = 32'(secs_reg[relay_st.phase_idx]) * MsPerSecond;
        elapsed = u.now_ms - relay_st.phase_start_ms;
        // Phase ends even under manual; even phases are on, so they end in off.
        if (elapsed >= limit) begin
          take_control(relay_st.phase_idx[0] ? ST_ON : ST_OFF);
          phases = 32'(count_reg);
          if (phases < MinPhases) phases = MinPhases;
          if (phases > MaxPhasesDef) phases = MaxPhasesDef;
          next_idx = 32'(relay_st.phase_idx) + 1;
          if (next_idx >= phases) next_idx = 0;
          relay_st.phase_idx      = PhaseIdxW'(next_idx);
          relay_st.phase_start_ms = u.now_ms;
        end
        relay_st.last_update_ms = u.now_ms;
      end
      MODE_AUX: begin
        if (!relay_st.manual)
          take_control(u.aux_demand ? ST_ON : ST_OFF);
      end
      default: begin
        // Unconfigured or undefined mode: relay level is held.
        drive_follows = 1'b0;
      end
    endcase

    if (drive_follows)
      relay_st.drive = (relay_st.cur_state == ST_ON || relay_st.cur_state == ST_MAN_ON);

    r.drive_on      = relay_st.drive;
    r.device_state  = relay_st.cur_state;
    r.state_changed = (relay_st.cur_state != prior);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic item_t mk_update(logic [1:0] btn, logic signed [31:0] level,
                                      logic valid, logic [31:0] now, logic hold,
                                      logic aux);
    item_t u;
    u.button_event = btn;
    u.sensor_value = level;
    u.sensor_valid = valid;
    u.now_ms       = now;
    u.paused       = hold;
    u.aux_demand   = aux;
    return u;
  endfunction

  // Mostly plausible updates: rare presses, readings near the threshold and a
  // clock that moves forward; now and then a jump of the clock or a wild reading.
  function automatic item_t random_update();
    item_t u;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 75)      u.button_event = BTN_NONE;
    else if (r < 86) u.button_event = BTN_SHORT;
    else if (r < 96) u.button_event = BTN_LONG;
    else             u.button_event = BTN_UNUSED;
    if ($urandom_range(0, 3) == 0) u.sensor_value = $urandom();
    else                           u.sensor_value = target_reg + $urandom_range(0, 8) - 4;
    u.sensor_valid = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
    else                            clock_ms = clock_ms + $urandom_range(0, 2500);
    u.now_ms     = clock_ms;
    u.paused     = ($urandom_range(0, 4) == 0);
    u.aux_demand = 1'($urandom_range(0, 1));
    return u;
  endfunction

  // One beat on the input stream; returns at the edge that accepts it.
  task automatic send_update(item_t u);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {3'b000, u.aux_demand, u.paused, u.now_ms, u.sensor_valid,
                      u.sensor_value, u.button_event};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering, wait until every pending result is back, let the pipe empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_CONTROL_MODE: mode_reg   = value[2:0];
      REG_TARGET_LEVEL: target_reg = value;
      REG_PHASE_COUNT:  count_reg  = value[2:0];
      default: begin
        if (idx >= REG_PHASE_SEC0 && 32'(idx - REG_PHASE_SEC0) < MaxPhasesDef)
          secs_reg[PhaseIdxW'(idx - REG_PHASE_SEC0)] = value[15:0];
      end
    endcase
  endtask

  // Random setting of every register, mostly the defined modes and short phases.
  task automatic configure_random();
    int         r;
    logic [2:0] mode;
    logic [31:0] level;
    logic [15:0] secs;
    r = $urandom_range(0, 99);
    if (r < 20)      mode = MODE_RAISE;
    else if (r < 40) mode = MODE_LOWER;
    else if (r < 70) mode = MODE_TIMED;
    else if (r < 88) mode = MODE_AUX;
    else             mode = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 5);
    if (r == 0)      level = LevelMin;
    else if (r == 1) level = LevelMax;
    else             level = $urandom_range(0, 2000) - 1000;
    write_reg(REG_CONTROL_MODE, 32'(mode));
    write_reg(REG_TARGET_LEVEL, level);
    write_reg(REG_PHASE_COUNT, $urandom_range(0, 7));
    for (int i = 0; i < MaxPhasesDef; i++) begin
      r = $urandom_range(0, 9);
      if (r == 9)      secs = 16'hFFFF;
      else if (r == 8) secs = 16'($urandom_range(0, 65535));
      else             secs = 16'($urandom_range(0, 3));
      write_reg(CfgIdxW'(REG_PHASE_SEC0 + i), 32'(secs));
    end
  endtask

  task automatic report_mismatch(string msg);
    if (mismatches < MaxPrinted) $display("[%0t] ERROR: %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset state, mode unconfigured: only the buttons act and the drive is held.
  task automatic test_unconfigured();
    send_update(mk_update(BTN_NONE, LevelMax, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_update(mk_update(BTN_SHORT, LevelMin, 1'b0, 32'h0, 1'b0, 1'b0));
    send_update(mk_update(BTN_LONG, 32'sd0, 1'b1, 32'd10, 1'b0, 1'b1));
    send_update(mk_update(BTN_LONG, 32'sd0, 1'b1, 32'd20, 1'b0, 1'b1));
    send_update(mk_update(BTN_UNUSED, -32'sd1, 1'b1, 32'd30, 1'b1, 1'b0));
    settle();
    write_reg(REG_CONTROL_MODE, 32'(MODE_SPARE));
    send_update(mk_update(BTN_SHORT, 32'sd5, 1'b1, 32'd40, 1'b0, 1'b1));
    settle();
  endtask

  // Raising and lowering thresholds at the level extremes, invalid readings,
  // manual hold.
  task automatic test_threshold();
    write_reg(REG_CONTROL_MODE, 32'(MODE_RAISE));
    write_reg(REG_TARGET_LEVEL, LevelMin);
    // Leaves manual on from the previous test, then sensor == target -> off.
    send_update(mk_update(BTN_SHORT, LevelMin, 1'b1, 32'd50, 1'b0, 1'b0));
    settle();
    write_reg(REG_TARGET_LEVEL, LevelMax);
    send_update(mk_update(BTN_NONE, LevelMin, 1'b1, 32'd60, 1'b0, 1'b0));
    send_update(mk_update(BTN_NONE, LevelMax, 1'b0, 32'd70, 1'b0, 1'b0));
    send_update(mk_update(BTN_LONG, LevelMin, 1'b1, 32'd80, 1'b0, 1'b0));
    settle();
    write_reg(REG_CONTROL_MODE, 32'(MODE_LOWER));
    write_reg(REG_TARGET_LEVEL, 32'sd0);
    send_update(mk_update(BTN_LONG, 32'sd1, 1'b1, 32'd90, 1'b0, 1'b0));
    send_update(mk_update(BTN_NONE, 32'sd0, 1'b1, 32'd100, 1'b0, 1'b0));
    settle();
  endtask

  // Timed cycle: zero and maximum durations, phase count clamping both ways,
  // index past the count after a rewrite, pause freeze, manual, time wrap.
  task automatic test_timed();
    logic [31:0] t;
    write_reg(REG_CONTROL_MODE, 32'(MODE_TIMED));
    write_reg(REG_PHASE_COUNT, 32'd7);
    for (int i = 0; i < MaxPhasesDef; i++)
      write_reg(CfgIdxW'(REG_PHASE_SEC0 + i), 32'd0);
    send_update(mk_update(BTN_NONE, 32'sd0, 1'b0, 32'd100, 1'b0, 1'b0));
    send_update(mk_update(BTN_NONE, 32'sd0, 1'b0, 32'd200, 1'b0, 1'b0));
    settle();
    // Index now sits at 3, above the clamped count of two.
    write_reg(REG_PHASE_COUNT, 32'd0);
    write_reg(REG_PHASE_SEC0, 32'd1);
    write_reg(CfgIdxW'(REG_PHASE_SEC0 + 3), 32'hFFFF);
    t = 32'd200 + 32'hFFFF * MsPerSecond;
    send_update(mk_update(BTN_NONE, 32'sd0, 1'b0, t - 1, 1'b0, 1'b0));
    send_update(mk_update(BTN_NONE, 32'sd0, 1'b0, t, 1'b0, 1'b0));
    send_update(mk_update(BTN_NONE, 32'sd0, 1'b0, t + 5000, 1'b1, 1'b0));
    send_update(mk_update(BTN_NONE, 32'sd0, 1'b0, t + 5999, 1'b0, 1'b0));
    send_update(mk_update(BTN_NONE, 32'sd0, 1'b0, t + 6000, 1'b0, 1'b0));
    // Zero-length phase ends under manual and overrides the manual state.
    send_update(mk_update(BTN_SHORT, 32'sd0, 1'b0, t + 6100, 1'b0, 1'b0));
    send_update(mk_update(BTN_SHORT, 32'sd0, 1'b0, 32'hFFFF_FC00, 1'b0, 1'b0));
    send_update(mk_update(BTN_SHORT, 32'sd0, 1'b0, 32'h0000_0100, 1'b1, 1'b0));
    settle();
  endtask

  // Auxiliary demand with a manual-off episode in between.
  task automatic test_aux();
    write_reg(REG_CONTROL_MODE, 32'(MODE_AUX));
    send_update(mk_update(BTN_NONE, 32'sd0, 1'b0, 32'd300, 1'b0, 1'b1));
    send_update(mk_update(BTN_NONE, 32'sd0, 1'b0, 32'd310, 1'b0, 1'b0));
    send_update(mk_update(BTN_LONG, 32'sd0, 1'b0, 32'd320, 1'b0, 1'b1));
    send_update(mk_update(BTN_LONG, 32'sd0, 1'b0, 32'd330, 1'b0, 1'b1));
    settle();
  endtask

  // Receiver holds off for a long stretch while the sender offers back to back.
  task automatic test_backpressure();
    configure_random();
    src_gaps_on   = 1'b0;
    sink_hold_len = LongHold;
    repeat (30) send_update(random_update());
    settle();
    src_gaps_on = 1'b1;
  endtask

  // Random updates over a series of random settings and idling patterns.
  task automatic test_random_phases(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      configure_random();
      src_gaps_on  = ($urandom_range(0, 3) != 0);
      sink_gaps_on = ($urandom_range(0, 3) != 0);
      repeat (per_phase) send_update(random_update());
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    // Predictor reset values match the block's reset.
    relay_st.cur_state      = ST_OFF;
    relay_st.last_ctl_state = ST_OFF;
    relay_st.manual         = 1'b0;
    relay_st.phase_idx      = PhaseIdxW'(1);
    relay_st.phase_start_ms = '0;
    relay_st.last_update_ms = '0;
    relay_st.drive          = 1'b0;
    mode_reg   = MODE_UNCFG;
    target_reg = '0;
    count_reg  = 3'(MinPhases);
    for (int i = 0; i < MaxPhasesDef; i++) secs_reg[i] = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unconfigured();
    test_threshold();
    test_timed();
    test_aux();
    test_backpressure();
    test_random_phases(8, 100);

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results_q.size() == 0) begin
      $display("relay_controller_with_manual_override: match");
    end else begin
      $display("relay_controller_with_manual_override: mismatch");
    end
    $finish;
  end

  // Result receiver: a random hold-off before each beat, or one long hold when
  // a test asks for it.
  initial begin : result_sink
    int gap;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (sink_hold_len > 0) begin
        gap           = sink_hold_len;
        sink_hold_len = 0;
      end else begin
        gap = sink_gaps_on ? $urandom_range(0, 6) : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Every accepted input beat yields one expected result.
  always @(posedge clk_i) begin : update_monitor
    item_t u;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      u.button_event = s_axis_tdata[1:0];
      u.sensor_value = s_axis_tdata[33:2];
      u.sensor_valid = s_axis_tdata[34];
      u.now_ms       = s_axis_tdata[66:35];
      u.paused       = s_axis_tdata[67];
      u.aux_demand   = s_axis_tdata[68];
      pending_results_q.push_back(predict_relay(u));
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    relay_out_t want;
    relay_out_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.drive_on      = m_axis_tdata[0];
      got.device_state  = m_axis_tdata[2:1];
      got.state_changed = m_axis_tdata[3];
      if (pending_results_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0h with no update pending", m_axis_tdata));
      end else begin
        want = pending_results_q.pop_front();
        if (got.drive_on !== want.drive_on)
          report_mismatch($sformatf("drive_on %0b, predicted %0b",
                                    got.drive_on, want.drive_on));
        if (got.device_state !== want.device_state)
          report_mismatch($sformatf("device_state %0d, predicted %0d",
                                    got.device_state, want.device_state));
        if (got.state_changed !== want.state_changed)
          report_mismatch($sformatf("state_changed %0b, predicted %0b",
                                    got.state_changed, want.state_changed));
      end
    end
  end

  // Hang detection: too long with no beat on either stream.
  always @(posedge clk_i) begin : stall_watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("relay_controller_with_manual_override: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
